// ===== rtl/rdse_pkg.sv =====
// shared types, widths and codes for the register dead store eliminator
package rdse_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int OFFSET_W      = 12;
    localparam int SIZE_W        = 5;
    localparam int INDEX_W       = 12;
    localparam int END_W         = OFFSET_W + 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // instruction opcodes
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_BARRIER = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_WRITE   = 2'd3;

    // classified command kinds
    localparam logic [1:0] CMD_NOP   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0]          opcode;
        logic                offset_known;
        logic [OFFSET_W-1:0] reg_offset;
        logic [SIZE_W-1:0]   access_size;
        logic [INDEX_W-1:0]  insn_index;
        logic                block_start;
    } in_item_t;

    typedef struct packed {
        logic                kill_valid;
        logic [INDEX_W-1:0]  kill_index;
    } out_item_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic                clear_first;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   size;
        logic [INDEX_W-1:0]  index;
    } cmd_t;

endpackage

// ===== rtl/register_dead_store_eliminator_core.sv =====
// top level of the register dead store eliminator
//
// tracks register-file writes not yet read and reports earlier writes that a
// later write with the same offset and size makes dead. one transaction is
// taken on each clock edge where start is high and busy is low; busy is the
// command queue being full, which stays low in normal use because the back
// part retires one command every cycle, so the block sustains one transaction
// per clock. every accepted transaction yields exactly one result, shown on
// result for a single cycle with result_strobe high, once it has passed
// through the command queue and then the table update and result
// register. results cannot be held off, so the receiver must take
// each one in the cycle it is strobed. the table holds 16 pending writes that
// are all compared in parallel; a full table simply drops the new write.
module register_dead_store_eliminator_core
    import rdse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      result_strobe,
    output out_item_t result
);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    assign busy = queue_full;

    // classify: barriers and dynamic offsets become clears
    rdse_front u_front (
        .start      (start),
        .queue_full (queue_full),
        .item       (item),
        .push       (push),
        .cmd        (front_cmd)
    );

    // decouples acceptance from table execution
    rdse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .pop_cmd  (back_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // pending write table and result register
    rdse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .cmd           (back_cmd),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// ===== rtl/rdse_front.sv =====
// front part: classifies an accepted instruction into a table command
module rdse_front
    import rdse_pkg::*;
(
    input  logic     start,
    input  logic     queue_full,
    input  in_item_t item,
    output logic     push,
    output cmd_t     cmd
);

    assign push = start && !queue_full;

    always_comb
    begin
        cmd.clear_first = item.block_start;
        cmd.offset      = item.reg_offset;
        cmd.size        = item.access_size;
        cmd.index       = item.insn_index;
        case (item.opcode)
            OP_NONE:    cmd.kind = CMD_NOP;
            OP_BARRIER: cmd.kind = CMD_CLEAR;
            OP_READ:    cmd.kind = item.offset_known ? CMD_READ : CMD_CLEAR;
            OP_WRITE:   cmd.kind = item.offset_known ? CMD_WRITE : CMD_CLEAR;
            default:    cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// ===== rtl/rdse_queue.sv =====
// short command queue between the front and back parts
module rdse_queue
    import rdse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue popped while empty");

endmodule

// ===== rtl/rdse_back.sv =====
// back part: pending write table, overlap and exact match logic, result register
module rdse_back
    import rdse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      queue_empty,
    input  cmd_t      cmd,
    output logic      pop,
    output logic      result_strobe,
    output out_item_t result
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [OFFSET_W-1:0]      off_reg [TABLE_ENTRIES];
    logic [SIZE_W-1:0]        size_reg [TABLE_ENTRIES];
    logic [INDEX_W-1:0]       idx_reg [TABLE_ENTRIES];
    logic                     strobe_reg;
    out_item_t                result_reg;
    out_item_t                result_next;

    logic [TABLE_ENTRIES-1:0] base;
    logic [TABLE_ENTRIES-1:0] off_eq;
    logic [TABLE_ENTRIES-1:0] exact;
    logic [TABLE_ENTRIES-1:0] overlap;
    logic [TABLE_ENTRIES-1:0] after_kill;
    logic [END_W-1:0]         r_end;
    logic [SLOT_W-1:0]        kill_slot;
    logic [SLOT_W-1:0]        free_slot;
    logic                     free_found;
    logic                     same_off;
    logic                     do_record;

    assign pop   = !queue_empty;
    assign r_end = END_W'(cmd.offset) + END_W'(cmd.size);
    assign base  = (cmd.clear_first || cmd.kind == CMD_CLEAR) ? '0 : valid_reg;

    // parallel compare against every slot
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            off_eq[i]  = (off_reg[i] == cmd.offset);
            exact[i]   = base[i] && off_eq[i] && (size_reg[i] == cmd.size);
            overlap[i] = base[i] && (END_W'(off_reg[i]) < r_end)
                      && (END_W'(cmd.offset) < (END_W'(off_reg[i]) + END_W'(size_reg[i])));
        end
    end

    assign after_kill = base & ~exact;
    assign same_off   = |(after_kill & off_eq);
    assign free_found = ~&after_kill;
    assign do_record  = (cmd.kind == CMD_WRITE) && !same_off && free_found;

    // lowest matching slot and lowest free slot
    always_comb
    begin
        kill_slot = '0;
        free_slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (exact[i])
            begin
                kill_slot = SLOT_W'(i);
            end
            if (!after_kill[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next  = valid_reg;
        result_next = '0;
        if (pop)
        begin
            case (cmd.kind)
                CMD_NOP:   valid_next = base;
                CMD_CLEAR: valid_next = '0;
                CMD_READ:  valid_next = base & ~overlap;
                CMD_WRITE:
                begin
                    valid_next = after_kill;
                    if (do_record)
                    begin
                        valid_next[free_slot] = 1'b1;
                    end
                    if (|exact)
                    begin
                        result_next.kill_valid = 1'b1;
                        result_next.kill_index = idx_reg[kill_slot];
                    end
                end
                default:   valid_next = base;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            strobe_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (pop && do_record)
        begin
            off_reg[free_slot]  <= cmd.offset;
            size_reg[free_slot] <= cmd.size;
            idx_reg[free_slot]  <= cmd.index;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (cmd.kind == CMD_CLEAR || cmd.clear_first) && cmd.kind != CMD_WRITE)
        |=> (valid_reg == '0))
        else $error("table not empty after clear");

    a_one_result_per_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> result_strobe)
        else $error("command produced no result");

    a_quiet_index: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.kill_valid) |-> (result.kill_index == '0))
        else $error("index set without kill");

    a_record_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && do_record) |=> valid_reg[$past(free_slot)])
        else $error("recorded write not held");

endmodule
